FILE: hdl/event_record_ring_buffer_macros.svh
// ----------------------------------------------------------------------------
// Event record ring buffer assertion macros
// Shared concurrent assertion forms with clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef EVENT_RECORD_RING_BUFFER_MACROS_SVH
`define EVENT_RECORD_RING_BUFFER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ERB_ASSERT_IMP(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ERB_ASSERT_NXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

FILE: hdl/erb_pkg.sv
// ----------------------------------------------------------------------------
// Event record ring buffer package
// Request and result payload types and fixed record constants.
// ----------------------------------------------------------------------------
package erb_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_OPEN   = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_CLOSE  = 2'd2;
    localparam logic [1:0] KIND_PULL   = 2'd3;

    localparam logic [7:0] HEADER_BYTES   = 8'd2;
    localparam logic [7:0] LIMIT_CAP      = 8'd248;
    localparam logic [7:0] MAX_REC_RESET  = 8'd192;
    localparam logic [2:0] DELTA_BYTES_MAX = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  severity;
        logic [62:0] timestamp;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  out_byte;
        logic [2:0]  out_severity;
        logic [62:0] record_time;
        logic        first_of_record;
        logic        last_of_record;
        logic        empty_res;
        logic        discontinuity;
        logic [31:0] tail_sequence;
        logic [15:0] dropped_records;
    } t_out_item;

endpackage

FILE: hdl/erb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module erb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/event_record_ring_buffer.sv
// ----------------------------------------------------------------------------
// Event record ring buffer
// Byte ring of variable-length log records with eviction and one reader.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; the input stalls until the result is
//   registered; each stored delta byte takes an S_DRD and an S_DCAP step.
// Reset: synchronous, active low; all pointers, times and counters clear,
//   max_record_bytes returns to 192; store contents are left as they are.
module event_record_ring_buffer
    import erb_pkg::*;
#(
    parameter int LOG_BYTES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
`include "event_record_ring_buffer_macros.svh"

    localparam int AW = $clog2(LOG_BYTES);
    localparam int QUARTER = LOG_BYTES / 4;
    localparam logic [7:0] LIMIT = (QUARTER > 248) ? LIMIT_CAP : 8'(QUARTER);
    localparam logic [16:0] RING_SIZE = 17'(LOG_BYTES);

    typedef enum logic [4:0] {
        S_IDLE, S_ROOM, S_EV0, S_EV1, S_EV2, S_EV3, S_DRD, S_DCAP,
        S_OPEN, S_APP, S_CW, S_CWL, S_CWF, S_P0, S_P1, S_P2, S_P3, S_P4, S_EMIT
    } t_state;

    t_state      r_state, r_ret, r_after;
    t_in_item    r_req;
    t_out_item   r_pend;
    t_out_item   r_out;
    logic        r_out_valid;
    logic [7:0]  r_max;
    logic [15:0] r_head, r_tail, r_rpos, r_dbase;
    logic [62:0] r_oldest, r_newest, r_open_time, r_rtime;
    logic [31:0] r_evseq;
    logic        r_rec_open;
    logic [7:0]  r_open_len, r_roff, r_len, r_need, r_total;
    logic [2:0]  r_open_sev, r_tl, r_k, r_flags_sev;
    logic [15:0] r_drops;
    logic [55:0] r_acc;
    logic        r_first, r_disc;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_q;

    erb_ram #(.WIDTH(8), .DEPTH(LOG_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Room check over byte counts.
    logic [15:0] used;
    logic        room_short;
    assign used = r_head - r_tail;
    assign room_short = ({1'b0, used} + {9'd0, r_need}) > RING_SIZE;

    // Delta of the record being closed, saturated to seven bytes.
    logic [62:0] diff;
    logic [55:0] sat_delta;
    logic [2:0]  sat_tl;
    always_comb begin
        diff = (r_open_time >= r_newest) ? (r_open_time - r_newest) : 63'd0;
        sat_delta = (diff[62:56] != 7'd0) ? {56{1'b1}} : diff[55:0];
        sat_tl = 3'd0;
        for (int b = 0; b < 7; b++) begin
            if (sat_delta[8*b +: 8] != 8'd0) begin
                sat_tl = 3'(b + 1);
            end
        end
    end

    // Message length and last-byte test for the record under the reader.
    logic [7:0] hdr_len, msg_len;
    logic [8:0] off_next;
    logic       pull_last;
    assign hdr_len = HEADER_BYTES + {5'd0, r_tl};
    assign msg_len = (r_len >= hdr_len) ? (r_len - hdr_len) : 8'd0;
    assign off_next = {1'b0, r_roff} + 9'd1;
    assign pull_last = (msg_len == 8'd0) || (off_next >= {1'b0, msg_len});

    // Store port selection per sequencer step.
    logic [15:0] rd_addr, wr_addr;
    always_comb begin
        rd_addr = r_tail;
        wr_addr = r_head;
        ram_we = 1'b0;
        ram_wdata = r_req.data_byte;
        case (r_state)
            S_EV0:   rd_addr = r_tail;
            S_EV1:   rd_addr = r_tail + 16'd1;
            S_DRD:   rd_addr = r_dbase + {13'd0, r_k};
            S_P0:    rd_addr = r_rpos;
            S_P1:    rd_addr = r_rpos + 16'd1;
            S_P3:    rd_addr = r_rpos + 16'd2 + {8'd0, r_roff};
            S_APP: begin
                ram_we = 1'b1;
                wr_addr = r_head + {8'd0, r_open_len};
            end
            S_CW: begin
                ram_we = (r_k != r_tl);
                wr_addr = r_head + {8'd0, r_open_len} + {13'd0, r_k};
                ram_wdata = r_acc[8*r_k +: 8];
            end
            S_CWL: begin
                ram_we = 1'b1;
                ram_wdata = r_total;
            end
            S_CWF: begin
                ram_we = 1'b1;
                wr_addr = r_head + 16'd1;
                ram_wdata = {2'b00, r_tl, r_open_sev};
            end
            default: ;
        endcase
    end
    assign ram_raddr = rd_addr[AW-1:0];
    assign ram_waddr = wr_addr[AW-1:0];

    // Sequencer, state registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_after <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max <= MAX_REC_RESET;
            r_head <= '0;
            r_tail <= '0;
            r_rpos <= '0;
            r_oldest <= '0;
            r_newest <= '0;
            r_open_time <= '0;
            r_rtime <= '0;
            r_evseq <= '0;
            r_rec_open <= 1'b0;
            r_open_len <= '0;
            r_open_sev <= '0;
            r_roff <= '0;
            r_drops <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if ((r_state == S_EMIT) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req <= i_in_data;
                        case (i_in_data.kind)
                            KIND_OPEN: begin
                                r_pend <= '0;
                                if (!r_rec_open) begin
                                    r_need <= HEADER_BYTES;
                                    r_after <= S_OPEN;
                                    r_state <= S_ROOM;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            KIND_APPEND: begin
                                r_pend <= '0;
                                if (r_rec_open && r_open_len < LIMIT && r_open_len < r_max) begin
                                    r_need <= r_open_len + 8'd1;
                                    r_after <= S_APP;
                                    r_state <= S_ROOM;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            KIND_CLOSE: begin
                                r_pend <= '0;
                                if (r_rec_open) begin
                                    r_total <= r_open_len + {5'd0, sat_tl};
                                    r_need <= r_open_len + {5'd0, sat_tl};
                                    r_after <= S_CW;
                                    r_state <= S_ROOM;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            default: begin
                                if (r_rpos == r_head) begin
                                    r_pend <= '{empty_res: 1'b1, default: '0};
                                    r_state <= S_EMIT;
                                end else begin
                                    r_pend <= '0;
                                    r_state <= S_P0;
                                end
                            end
                        endcase
                    end
                end
                S_ROOM: begin
                    if (room_short && r_head != r_tail) begin
                        r_state <= S_EV0;
                    end else begin
                        // Eviction reuses the delta registers, so the close
                        // loads its delta only once room is made.
                        if (r_after == S_CW) begin
                            r_acc <= sat_delta;
                            r_tl <= sat_tl;
                            r_k <= 3'd0;
                        end
                        r_state <= r_after;
                    end
                end
                S_EV0: r_state <= S_EV1;
                S_EV1: begin
                    r_len <= ram_q;
                    r_state <= S_EV2;
                end
                S_EV2: begin
                    r_tl <= ram_q[5:3];
                    r_dbase <= r_tail + {8'd0, r_len} - {13'd0, ram_q[5:3]};
                    r_k <= 3'd0;
                    r_acc <= '0;
                    r_ret <= S_EV3;
                    r_state <= S_DRD;
                end
                S_EV3: begin
                    r_oldest <= r_oldest + {7'd0, r_acc};
                    r_evseq <= r_evseq + 32'd1;
                    if (r_rpos == r_tail) begin
                        r_rpos <= r_rpos + {8'd0, r_len};
                        r_roff <= '0;
                        r_drops <= r_drops + 16'd1;
                    end
                    r_tail <= r_tail + {8'd0, r_len};
                    r_state <= S_ROOM;
                end
                S_DRD: begin
                    r_state <= (r_k == r_tl) ? r_ret : S_DCAP;
                end
                S_DCAP: begin
                    r_acc[8*r_k +: 8] <= ram_q;
                    r_k <= r_k + 3'd1;
                    r_state <= S_DRD;
                end
                S_OPEN: begin
                    if (r_head == r_tail) begin
                        r_oldest <= r_req.timestamp;
                        r_newest <= r_req.timestamp;
                    end
                    r_rec_open <= 1'b1;
                    r_open_len <= HEADER_BYTES;
                    r_open_time <= r_req.timestamp;
                    r_open_sev <= r_req.severity;
                    r_pend.accepted <= 1'b1;
                    r_state <= S_EMIT;
                end
                S_APP: begin
                    r_open_len <= r_open_len + 8'd1;
                    r_pend.accepted <= 1'b1;
                    r_state <= S_EMIT;
                end
                S_CW: begin
                    if (r_k == r_tl) begin
                        r_state <= S_CWL;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_CWL: r_state <= S_CWF;
                S_CWF: begin
                    r_newest <= r_open_time;
                    r_head <= r_head + {8'd0, r_total};
                    r_rec_open <= 1'b0;
                    r_open_len <= '0;
                    r_pend.accepted <= 1'b1;
                    r_state <= S_EMIT;
                end
                S_P0: r_state <= S_P1;
                S_P1: begin
                    r_len <= ram_q;
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_tl <= ram_q[5:3];
                    r_flags_sev <= ram_q[2:0];
                    r_dbase <= r_rpos + {8'd0, r_len} - {13'd0, ram_q[5:3]};
                    r_k <= 3'd0;
                    r_acc <= '0;
                    r_ret <= S_P3;
                    r_state <= (r_roff == 8'd0) ? S_DRD : S_P3;
                end
                S_P3: begin
                    r_first <= (r_roff == 8'd0);
                    r_disc <= (r_roff == 8'd0) && (r_rpos == r_tail);
                    if (r_roff == 8'd0) begin
                        r_rtime <= ((r_rpos == r_tail) ? r_oldest : r_rtime) + {7'd0, r_acc};
                    end
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_pend.accepted <= 1'b1;
                    r_pend.out_byte <= (msg_len != 8'd0) ? ram_q : 8'd0;
                    r_pend.out_severity <= r_flags_sev;
                    r_pend.record_time <= r_rtime;
                    r_pend.first_of_record <= r_first;
                    r_pend.discontinuity <= r_disc;
                    r_pend.last_of_record <= pull_last;
                    if (pull_last) begin
                        r_rpos <= r_rpos + {8'd0, r_len};
                        r_roff <= '0;
                        r_pend.empty_res <= ((r_rpos + {8'd0, r_len}) == r_head);
                    end else begin
                        r_roff <= r_roff + 8'd1;
                        r_pend.empty_res <= (r_rpos == r_head);
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out <= {r_pend[$bits(t_out_item)-1:$bits(r_evseq)+$bits(r_drops)],
                                  r_evseq, r_drops};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;
    assign o_cfg_ready = 1'b1;

    // Checks on ring bookkeeping and sequencing.
    `ERB_ASSERT_IMP(a_ring_bound, i_clk, i_rst_n, 1'b1, ({1'b0, used} <= RING_SIZE))
    `ERB_ASSERT_IMP(a_open_len, i_clk, i_rst_n, r_rec_open, (r_open_len >= HEADER_BYTES))
    `ERB_ASSERT_NXT(a_emit_hold, i_clk, i_rst_n, (r_state == S_EMIT && r_out_valid && i_out_stall), (r_state == S_EMIT))
    `ERB_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, (i_in_valid && !o_in_stall), (r_state != S_IDLE))

endmodule
